### hdl/photometric_residual_jacobian_defines.svh
// Assertion macros used by the checker of the photometric Jacobian block.
`ifndef PHOTOMETRIC_RESIDUAL_JACOBIAN_DEFINES_SVH
`define PHOTOMETRIC_RESIDUAL_JACOBIAN_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define PRJ_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Condition holds in the cycle after the trigger.
`define PRJ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hdl/prj_pkg.sv
package prj_pkg;

   localparam int MAX_IMAGE_SIDE_DEF = 4096;
   localparam int REQ_DATA_W = 208;
   localparam int RSP_DATA_W = 216;
   localparam int DIV_STEPS  = 33;

   localparam logic [15:0] FOCAL_X_RST      = 16'd8320;
   localparam logic [15:0] FOCAL_Y_RST      = 16'd8320;
   localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

   typedef enum logic [1:0] {
      CSR_FOCAL_X,
      CSR_FOCAL_Y,
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT
   } csr_index_type;

   // one lane of the restoring divider; num shifts out dividend, shifts in quotient
   typedef struct packed {
      logic [31:0] rem;
      logic [32:0] num;
      logic        neg;
      logic        ovf;
   } div_lane_type;

   typedef struct packed {
      logic [31:0]        pz;
      logic signed [31:0] gx;
      logic signed [31:0] gy;
      logic [16:0]        res;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -36'sh080000000) return 32'sh80000000;
      return v[31:0];
   endfunction

   // round p/65536 to nearest, ties away from zero, then saturate
   function automatic logic signed [31:0] qround(input logic signed [63:0] p);
      logic [63:0] mag;
      logic [63:0] rnd;
      mag = p[63] ? 64'(-p) : 64'(p);
      rnd = (mag + 64'd32768) >> 16;
      if (p[63]) begin
         if (rnd > 64'h80000000) return 32'sh80000000;
         return 32'(-rnd);
      end
      if (rnd > 64'h7FFFFFFF) return 32'sh7FFFFFFF;
      return rnd[31:0];
   endfunction

   function automatic div_lane_type div_step(input div_lane_type l, input logic [31:0] d);
      logic [32:0]  sh;
      logic         ge;
      div_lane_type r;
      sh = {l.rem, l.num[32]};
      ge = sh >= {1'b0, d};
      r = l;
      r.rem = ge ? 32'(sh - {1'b0, d}) : sh[31:0];
      r.num = {l.num[31:0], ge};
      return r;
   endfunction

   function automatic logic signed [31:0] div_result(input div_lane_type l);
      if (l.neg) begin
         if (l.ovf || l.num > 33'h080000000) return 32'sh80000000;
         return 32'(-l.num);
      end
      if (l.ovf || l.num > 33'h07FFFFFFF) return 32'sh7FFFFFFF;
      return l.num[31:0];
   endfunction

endpackage

### hdl/photometric_residual_jacobian.sv
// Throughput: one request per cycle unless the output stalls; the 33-stage
//    restoring divider that forms a, b, u and v sets the depth, each stage
//    retiring one quotient bit.
// Stall: the whole pipeline holds while a result waits on rsp_tready.
// Reset: synchronous, active high; clears all valid bits and loads the
//    register defaults (focal 520.0, image 640 x 480).
module photometric_residual_jacobian
   import prj_pkg::*;
#(
   parameter int MAX_IMAGE_SIDE = MAX_IMAGE_SIDE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // warp_col[20:0], warp_row[41:21], ref_intensity[57:42],
   // warped_intensity[73:58], grad_horiz[89:74], grad_vert[105:90],
   // point_x[137:106], point_y[169:138], point_z[201:170], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // point_present[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // residual[16:0], jac_tx[48:17], jac_ty[80:49], jac_tz[112:81],
   // jac_rx[144:113], jac_ry[176:145], jac_rz[208:177], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata
);

   localparam logic [12:0] SIDE_MAX = 13'(MAX_IMAGE_SIDE);

   logic        adv;
   logic [15:0] focal_x_ff, focal_y_ff;
   logic [12:0] image_width_ff, image_height_ff;

   // advance every stage when the output register is free or being taken
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff      <= FOCAL_X_RST;
         focal_y_ff      <= FOCAL_Y_RST;
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FOCAL_X:      focal_x_ff      <= csr_wdata;
            CSR_FOCAL_Y:      focal_y_ff      <= csr_wdata;
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[12:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: request register ----------------
   logic               v1_ff;
   logic signed [20:0] col1_ff, row1_ff;
   logic [15:0]        iref1_ff, iwarp1_ff;
   logic signed [15:0] gh1_ff, gv1_ff;
   logic signed [31:0] px1_ff, py1_ff, pz1_ff;
   logic               pres1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         col1_ff   <= req_tdata[20:0];
         row1_ff   <= req_tdata[41:21];
         iref1_ff  <= req_tdata[57:42];
         iwarp1_ff <= req_tdata[73:58];
         gh1_ff    <= req_tdata[89:74];
         gv1_ff    <= req_tdata[105:90];
         px1_ff    <= req_tdata[137:106];
         py1_ff    <= req_tdata[169:138];
         pz1_ff    <= req_tdata[201:170];
         pres1_ff  <= req_tuser;
      end
   end

   // bounds and validity test
   logic [12:0]        w_side, h_side;
   logic signed [22:0] col_lim, row_lim, col_x, row_x;
   logic               keep1;

   always_comb begin
      w_side  = (image_width_ff > SIDE_MAX) ? SIDE_MAX : image_width_ff;
      h_side  = (image_height_ff > SIDE_MAX) ? SIDE_MAX : image_height_ff;
      col_lim = ($signed({10'd0, w_side}) - 23'sd2) <<< 8;
      row_lim = ($signed({10'd0, h_side}) - 23'sd2) <<< 8;
      col_x   = {{2{col1_ff[20]}}, col1_ff};
      row_x   = {{2{row1_ff[20]}}, row1_ff};
      keep1   = (col_x > 23'sd256) && (col_x < col_lim) &&
                (row_x > 23'sd256) && (row_x < row_lim) &&
                (iwarp1_ff != 16'd0) && pres1_ff && (pz1_ff > 32'sd0);
   end

   // ---------------- stage 2: focal scaling ----------------
   logic               v2_ff;
   logic signed [32:0] fgx2_ff, fgy2_ff;
   logic signed [31:0] px2_ff, py2_ff, pz2_ff;
   logic [16:0]        res2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         fgx2_ff <= gh1_ff * $signed({1'b0, focal_x_ff});
         fgy2_ff <= gv1_ff * $signed({1'b0, focal_y_ff});
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         pz2_ff  <= pz1_ff;
         res2_ff <= 17'({1'b0, iref1_ff} - {1'b0, iwarp1_ff});
      end
   end

   // ---------------- stage 3: dividend magnitudes with rounding bias ----------------
   logic               v3_ff;
   logic [47:0]        ma3_ff, mb3_ff, mu3_ff, mv3_ff;
   logic [3:0]         neg3_ff;
   side_type           side3_ff;
   logic [31:0]        mag_fx, mag_fy, mag_px, mag_py;
   logic [31:0]        rgx, rgy;

   always_comb begin
      mag_fx = fgx2_ff[32] ? 32'(-fgx2_ff) : fgx2_ff[31:0];
      mag_fy = fgy2_ff[32] ? 32'(-fgy2_ff) : fgy2_ff[31:0];
      mag_px = px2_ff[31] ? 32'(-px2_ff) : px2_ff;
      mag_py = py2_ff[31] ? 32'(-py2_ff) : py2_ff;
      rgx    = (mag_fx + 32'd4) >> 3;
      rgy    = (mag_fy + 32'd4) >> 3;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma3_ff       <= {3'd0, mag_fx, 13'd0} + 48'(pz2_ff[31:1]);
         mb3_ff       <= {3'd0, mag_fy, 13'd0} + 48'(pz2_ff[31:1]);
         mu3_ff       <= {mag_px, 16'd0} + 48'(pz2_ff[31:1]);
         mv3_ff       <= {mag_py, 16'd0} + 48'(pz2_ff[31:1]);
         neg3_ff      <= {py2_ff[31], px2_ff[31], fgy2_ff[32], fgx2_ff[32]};
         side3_ff.pz  <= pz2_ff;
         side3_ff.gx  <= fgx2_ff[32] ? -$signed(rgx) : $signed(rgx);
         side3_ff.gy  <= fgy2_ff[32] ? -$signed(rgy) : $signed(rgy);
         side3_ff.res <= res2_ff;
      end
   end

   // ---------------- divider: init register plus one stage per quotient bit ----------------
   logic         dv_ff   [0:DIV_STEPS];
   div_lane_type lane_ff [0:DIV_STEPS][4];
   side_type     side_ff [0:DIV_STEPS];
   logic [47:0]  mnum    [4];

   assign mnum[0] = ma3_ff;
   assign mnum[1] = mb3_ff;
   assign mnum[2] = mu3_ff;
   assign mnum[3] = mv3_ff;

   // start with the upper dividend bits as remainder; quotient beyond 33 bits saturates
   for (genvar i = 0; i < 4; i++) begin : g_init
      always_ff @(posedge clock) begin
         if (adv) begin
            lane_ff[0][i].rem <= {17'd0, mnum[i][47:33]};
            lane_ff[0][i].num <= mnum[i][32:0];
            lane_ff[0][i].neg <= neg3_ff[i];
            lane_ff[0][i].ovf <= {17'd0, mnum[i][47:33]} >= side3_ff.pz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) side_ff[0] <= side3_ff;
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) dv_ff[k] <= 1'b0;
         else if (adv) dv_ff[k] <= dv_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (adv) side_ff[k] <= side_ff[k-1];
      end
      for (genvar i = 0; i < 4; i++) begin : g_lane
         always_ff @(posedge clock) begin
            if (adv) lane_ff[k][i] <= div_step(lane_ff[k-1][i], side_ff[k-1].pz);
         end
      end
   end

   // ---------------- stage p1: signed, saturated quotients ----------------
   logic               vp1_ff;
   logic signed [31:0] a1_ff, b1_ff, u1_ff, v1q_ff, gx1_ff, gy1_ff;
   logic [16:0]        resp1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff    <= div_result(lane_ff[DIV_STEPS][0]);
         b1_ff    <= div_result(lane_ff[DIV_STEPS][1]);
         u1_ff    <= div_result(lane_ff[DIV_STEPS][2]);
         v1q_ff   <= div_result(lane_ff[DIV_STEPS][3]);
         gx1_ff   <= side_ff[DIV_STEPS].gx;
         gy1_ff   <= side_ff[DIV_STEPS].gy;
         resp1_ff <= side_ff[DIV_STEPS].res;
      end
   end

   // ---------------- stage p2: first products ----------------
   logic               vp2_ff;
   logic signed [63:0] au2_ff, bv2_ff, uv2_ff, uu2_ff, vv2_ff, gxv2_ff, gyu2_ff;
   logic signed [31:0] a2_ff, b2_ff, gx2_ff, gy2_ff;
   logic [16:0]        resp2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         au2_ff   <= a1_ff * u1_ff;
         bv2_ff   <= b1_ff * v1q_ff;
         uv2_ff   <= u1_ff * v1q_ff;
         uu2_ff   <= u1_ff * u1_ff;
         vv2_ff   <= v1q_ff * v1q_ff;
         gxv2_ff  <= gx1_ff * v1q_ff;
         gyu2_ff  <= gy1_ff * u1_ff;
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         gx2_ff   <= gx1_ff;
         gy2_ff   <= gy1_ff;
         resp2_ff <= resp1_ff;
      end
   end

   // ---------------- stage p3: round first products ----------------
   logic               vp3_ff;
   logic signed [31:0] au3_ff, bv3_ff, uv3_ff, uu3_ff, vv3_ff, gxv3_ff, gyu3_ff;
   logic signed [31:0] a3_ff, b3_ff, gx3_ff, gy3_ff;
   logic [16:0]        resp3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         au3_ff   <= qround(au2_ff);
         bv3_ff   <= qround(bv2_ff);
         uv3_ff   <= qround(uv2_ff);
         uu3_ff   <= qround(uu2_ff);
         vv3_ff   <= qround(vv2_ff);
         gxv3_ff  <= qround(gxv2_ff);
         gyu3_ff  <= qround(gyu2_ff);
         a3_ff    <= a2_ff;
         b3_ff    <= b2_ff;
         gx3_ff   <= gx2_ff;
         gy3_ff   <= gy2_ff;
         resp3_ff <= resp2_ff;
      end
   end

   // ---------------- stage p4: second products ----------------
   logic               vp4_ff;
   logic signed [63:0] gxuv4_ff, gyvv4_ff, gxuu4_ff, gyuv4_ff;
   logic signed [31:0] au4_ff, bv4_ff, gxv4_ff, gyu4_ff, a4_ff, b4_ff, gx4_ff, gy4_ff;
   logic [16:0]        resp4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         gxuv4_ff <= gx3_ff * uv3_ff;
         gyvv4_ff <= gy3_ff * vv3_ff;
         gxuu4_ff <= gx3_ff * uu3_ff;
         gyuv4_ff <= gy3_ff * uv3_ff;
         au4_ff   <= au3_ff;
         bv4_ff   <= bv3_ff;
         gxv4_ff  <= gxv3_ff;
         gyu4_ff  <= gyu3_ff;
         a4_ff    <= a3_ff;
         b4_ff    <= b3_ff;
         gx4_ff   <= gx3_ff;
         gy4_ff   <= gy3_ff;
         resp4_ff <= resp3_ff;
      end
   end

   // ---------------- stage p5: round second products ----------------
   logic               vp5_ff;
   logic signed [31:0] gxuv5_ff, gyvv5_ff, gxuu5_ff, gyuv5_ff;
   logic signed [31:0] au5_ff, bv5_ff, gxv5_ff, gyu5_ff, a5_ff, b5_ff, gx5_ff, gy5_ff;
   logic [16:0]        resp5_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         gxuv5_ff <= qround(gxuv4_ff);
         gyvv5_ff <= qround(gyvv4_ff);
         gxuu5_ff <= qround(gxuu4_ff);
         gyuv5_ff <= qround(gyuv4_ff);
         au5_ff   <= au4_ff;
         bv5_ff   <= bv4_ff;
         gxv5_ff  <= gxv4_ff;
         gyu5_ff  <= gyu4_ff;
         a5_ff    <= a4_ff;
         b5_ff    <= b4_ff;
         gx5_ff   <= gx4_ff;
         gy5_ff   <= gy4_ff;
         resp5_ff <= resp4_ff;
      end
   end

   // ---------------- output register: exact sums, then saturate ----------------
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic signed [31:0]    j_tx, j_ty, j_tz, j_rx, j_ry, j_rz;

   always_comb begin
      j_tx = sat32(-36'(a5_ff));
      j_ty = sat32(-36'(b5_ff));
      j_tz = sat32(36'(au5_ff) + 36'(bv5_ff));
      j_rx = sat32(36'(gxuv5_ff) + 36'(gy5_ff) + 36'(gyvv5_ff));
      j_ry = sat32(-(36'(gx5_ff) + 36'(gxuu5_ff) + 36'(gyuv5_ff)));
      j_rz = sat32(36'(gxv5_ff) - 36'(gyu5_ff));
      rsp_data_in = {7'd0, j_rz, j_ry, j_rx, j_tz, j_ty, j_tx, resp5_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) rsp_data_ff <= rsp_data_in;
   end

   // valid bits travel with the data; dropped pixels become bubbles in stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         dv_ff[0]     <= 1'b0;
         vp1_ff       <= 1'b0;
         vp2_ff       <= 1'b0;
         vp3_ff       <= 1'b0;
         vp4_ff       <= 1'b0;
         vp5_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff && keep1;
         v3_ff        <= v2_ff;
         dv_ff[0]     <= v3_ff;
         vp1_ff       <= dv_ff[DIV_STEPS];
         vp2_ff       <= vp1_ff;
         vp3_ff       <= vp2_ff;
         vp4_ff       <= vp3_ff;
         vp5_ff       <= vp4_ff;
         rsp_valid_ff <= vp5_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### hdl/prj_checker.sv
`include "photometric_residual_jacobian_defines.svh"

module prj_checker
   import prj_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds its value
   `PRJ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // with the output register empty the pipeline takes requests
   `PRJ_ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

   // a result taken frees the pipeline in the same cycle
   `PRJ_ASSERT_SAME(a_ready_on_take, clock, reset, rsp_tvalid && rsp_tready, req_tready)

   // a stalled result blocks new requests
   `PRJ_ASSERT_SAME(a_block_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

endmodule

bind photometric_residual_jacobian prj_checker u_prj_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
